FILE: sv/tfsd_pkg.sv
// ---------------------------------------------------------------------------
// tfsd_pkg
// Shared constants, types and helpers of the tracker frame sync decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package tfsd_pkg;

    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int POS_W      = 19;
    localparam int EXP_W      = 2;
    localparam int COUNT_W    = 4;
    localparam int INDEX_W    = 3;
    localparam int FRAME_LEN  = 8;
    localparam int STORE_LEN  = FRAME_LEN - 1;
    localparam int LOCK_COUNT = 8;
    localparam int KEEP_COUNT = 2;

    localparam int TDATA_BITS = 3 * POS_W + EXP_W;
    localparam int M_TDATA_W  = ((TDATA_BITS + 7) / 8) * 8;
    localparam int PAD_W      = M_TDATA_W - TDATA_BITS;

    localparam logic [BYTE_W-1:0] SYNC_MASK   = 8'hf0;
    localparam logic [BYTE_W-1:0] SYNC_NIBBLE = 8'h80;

    // tuser codes
    localparam logic STATUS_POS  = 1'b0;
    localparam logic STATUS_LOST = 1'b1;

    // one completed frame, as seen on the accepting edge
    typedef struct packed {
        logic                    lost;
        logic [EXP_W-1:0]        exponent;
        logic signed [RAW_W-1:0] raw_x;
        logic signed [RAW_W-1:0] raw_y;
        logic signed [RAW_W-1:0] raw_z;
    } frame_evt_t;

    function automatic logic is_sync(input logic [BYTE_W-1:0] b);
        return (b & SYNC_MASK) == SYNC_NIBBLE;
    endfunction

    function automatic logic signed [POS_W-1:0] scale_coord(
        input logic signed [RAW_W-1:0] raw,
        input logic [EXP_W-1:0]        e
    );
        logic signed [POS_W-1:0] ext;
        ext = {{(POS_W-RAW_W){raw[RAW_W-1]}}, raw};
        return ext <<< e;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tfsd_sync_ctrl.sv
// ---------------------------------------------------------------------------
// tfsd_sync_ctrl
// Sync hunt, lock tracking and frame byte store; flags the frame-ending byte.
// ---------------------------------------------------------------------------
`default_nettype none

module tfsd_sync_ctrl (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept,
    input  wire logic [tfsd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                              frame_end,   // next byte closes a frame
    output tfsd_pkg::frame_evt_t              evt
);

    logic                             locked_reg, locked_next;
    logic [tfsd_pkg::COUNT_W-1:0]     hunt_count_reg, hunt_count_next;
    logic [tfsd_pkg::INDEX_W-1:0]     byte_index_reg, byte_index_next;
    logic [tfsd_pkg::BYTE_W-1:0]      frame_reg [tfsd_pkg::STORE_LEN];
    logic [tfsd_pkg::COUNT_W-1:0]     hunt_inc;

    assign frame_end = locked_reg &&
                       (byte_index_reg == tfsd_pkg::INDEX_W'(tfsd_pkg::STORE_LEN));

    // frame decode from the stored bytes and the closing byte
    always_comb begin
        evt.lost     = !tfsd_pkg::is_sync(frame_reg[0]) || !tfsd_pkg::is_sync(frame_reg[1]);
        evt.exponent = frame_reg[0][tfsd_pkg::EXP_W-1:0];
        evt.raw_x    = {frame_reg[2], frame_reg[3]};
        evt.raw_y    = {frame_reg[4], frame_reg[5]};
        evt.raw_z    = {frame_reg[6], rx_byte};
    end

    always_comb begin
        locked_next     = locked_reg;
        hunt_count_next = hunt_count_reg;
        byte_index_next = byte_index_reg;
        hunt_inc        = hunt_count_reg + 1'b1;
        if (accept) begin
            if (!locked_reg) begin
                if (tfsd_pkg::is_sync(rx_byte) ||
                    hunt_count_reg >= tfsd_pkg::COUNT_W'(tfsd_pkg::KEEP_COUNT)) begin
                    hunt_count_next = hunt_inc;
                end else begin
                    hunt_count_next = '0;
                end
                if (hunt_count_next >= tfsd_pkg::COUNT_W'(tfsd_pkg::LOCK_COUNT)) begin
                    locked_next     = 1'b1;
                    hunt_count_next = '0;
                    byte_index_next = '0;
                end
            end else if (!frame_end) begin
                byte_index_next = byte_index_reg + 1'b1;
            end else begin
                byte_index_next = '0;
                if (evt.lost) begin
                    locked_next     = 1'b0;
                    hunt_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg     <= 1'b0;
            hunt_count_reg <= '0;
            byte_index_reg <= '0;
        end else begin
            locked_reg     <= locked_next;
            hunt_count_reg <= hunt_count_next;
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && locked_reg && !frame_end) begin
            frame_reg[byte_index_reg] <= rx_byte;
        end
    end

    a_count_clear_when_locked: assert property (
        @(posedge aclk) disable iff (!aresetn)
        locked_reg |-> hunt_count_reg == '0
    ) else $error("hunt count not cleared while locked");

    a_index_zero_when_hunting: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !locked_reg |-> byte_index_reg == '0
    ) else $error("byte index moved while hunting");

    a_count_below_lock: assert property (
        @(posedge aclk) disable iff (!aresetn)
        hunt_count_reg < tfsd_pkg::COUNT_W'(tfsd_pkg::LOCK_COUNT)
    ) else $error("hunt count reached lock value without locking");

endmodule

`default_nettype wire

FILE: sv/tfsd_out_stage.sv
// ---------------------------------------------------------------------------
// tfsd_out_stage
// Coordinate scaling and the registered result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module tfsd_out_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire tfsd_pkg::frame_evt_t           evt,
    output logic                                space,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // pos_x, pos_y, pos_z, exponent, zero pad
    output logic [tfsd_pkg::M_TDATA_W-1:0]      m_tdata,
    // status
    output logic [0:0]                          m_tuser
);

    logic                                 valid_reg, valid_next;
    logic [tfsd_pkg::M_TDATA_W-1:0]       data_reg, data_next;
    logic                                 status_reg, status_next;
    logic signed [tfsd_pkg::POS_W-1:0]    pos_x, pos_y, pos_z;

    assign space = !valid_reg || m_tready;

    always_comb begin
        pos_x = tfsd_pkg::scale_coord(evt.raw_x, evt.exponent);
        pos_y = tfsd_pkg::scale_coord(evt.raw_y, evt.exponent);
        pos_z = tfsd_pkg::scale_coord(evt.raw_z, evt.exponent);
        valid_next  = valid_reg && !m_tready;
        data_next   = data_reg;
        status_next = status_reg;
        if (load) begin
            valid_next = 1'b1;
            if (evt.lost) begin
                status_next = tfsd_pkg::STATUS_LOST;
                data_next   = '0;
            end else begin
                status_next = tfsd_pkg::STATUS_POS;
                data_next   = {{tfsd_pkg::PAD_W{1'b0}}, evt.exponent, pos_z, pos_y, pos_x};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;

    a_lost_carries_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg == tfsd_pkg::STATUS_LOST) |-> data_reg == '0
    ) else $error("lost-sync report with non-zero payload");

    a_no_overwrite: assert property (
        @(posedge aclk) disable iff (!aresetn)
        load |-> space
    ) else $error("result loaded over one not yet taken");

endmodule

`default_nettype wire

FILE: sv/tracker_frame_sync_decoder.sv
// ---------------------------------------------------------------------------
// tracker_frame_sync_decoder
// Hunts for sync in a tracker byte stream and decodes 8-byte position frames.
// ---------------------------------------------------------------------------
// One byte is taken per cycle. Hunting and the first seven bytes of a frame
// give no result and are always accepted; the eighth byte of a frame yields
// one result, registered and shown on the master side in the next cycle, and
// that byte is held back only while an earlier result is still waiting. A
// result with tuser status 0 carries the three coordinates, sign-extended and
// shifted left by the frame exponent; status 1 reports lost sync with an
// all-zero payload, after which the block hunts again.
`default_nettype none

module tracker_frame_sync_decoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // rx_byte
    input  wire logic [7:0]                    s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pos_x [18:0], pos_y [37:19], pos_z [56:38], exponent [58:57], zero pad
    output logic [tfsd_pkg::M_TDATA_W-1:0]     m_tdata,
    // status
    output logic [0:0]                         m_tuser
);

    logic                  accept;
    logic                  frame_end;
    logic                  space;
    tfsd_pkg::frame_evt_t  evt;

    assign s_tready = !frame_end || space;
    assign accept   = s_tvalid && s_tready;

    tfsd_sync_ctrl u_sync_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .frame_end (frame_end),
        .evt       (evt)
    );

    tfsd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept && frame_end),
        .evt      (evt),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: sim/tfsd_decode_checker.sv
// ---------------------------------------------------------------------------
// tfsd_decode_checker
// Tracks the byte stream into the decoder and checks every frame it reports.
// ---------------------------------------------------------------------------
// Every byte request accepted on the slave side is decoded by a local copy of
// the sync hunter and frame gatherer. A completed frame queues the report it
// should produce. Every report accepted on the master side is compared, field
// by field, with the oldest queued one.

module tfsd_decode_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [7:0]                      s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [tfsd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic [0:0]                      m_tuser,
    output int                                   n_mismatch,
    output int                                   n_pending,
    output int                                   n_pos_frames,
    output int                                   n_lost_frames
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       status;
        logic [tfsd_pkg::POS_W-1:0] x;
        logic [tfsd_pkg::POS_W-1:0] y;
        logic [tfsd_pkg::POS_W-1:0] z;
        logic [tfsd_pkg::EXP_W-1:0] expo;
    } pos_report_t;

    pos_report_t      frames_due [$];

    logic             in_lock;
    logic [3:0]       sync_run;
    logic [2:0]       slot;
    logic [7:0]       frame_buf [0:tfsd_pkg::STORE_LEN-1];

    function automatic logic [tfsd_pkg::POS_W-1:0] widen_coord(
        input logic [7:0]                 hi,
        input logic [7:0]                 lo,
        input logic [tfsd_pkg::EXP_W-1:0] e
    );
        logic [tfsd_pkg::POS_W-1:0] w;
        w = {{(tfsd_pkg::POS_W-16){hi[7]}}, hi, lo};
        return w << e;
    endfunction

    // one accepted byte through the hunter and frame gatherer
    task automatic decode_rx_byte(input logic [7:0] b);
        int          run_next;
        pos_report_t r;
        logic        b_sync;
        if (!in_lock) begin
            b_sync = (b[7:4] == tfsd_pkg::SYNC_NIBBLE[7:4]);
            if (b_sync)
                run_next = sync_run + 1;
            else if (sync_run < tfsd_pkg::KEEP_COUNT)
                run_next = 0;
            else
                run_next = sync_run + 1;
            if (run_next >= tfsd_pkg::LOCK_COUNT) begin
                in_lock  = 1'b1;
                sync_run = '0;
                slot     = '0;
            end else begin
                sync_run = run_next[3:0];
            end
        end else if (slot != tfsd_pkg::FRAME_LEN - 1) begin
            frame_buf[slot] = b;
            slot = slot + 3'd1;
        end else begin
            slot = '0;
            if (frame_buf[0][7:4] != tfsd_pkg::SYNC_NIBBLE[7:4] ||
                frame_buf[1][7:4] != tfsd_pkg::SYNC_NIBBLE[7:4]) begin
                in_lock  = 1'b0;
                sync_run = '0;
                r        = '0;
                r.status = tfsd_pkg::STATUS_LOST;
            end else begin
                r.status = tfsd_pkg::STATUS_POS;
                r.expo   = frame_buf[0][tfsd_pkg::EXP_W-1:0];
                r.x      = widen_coord(frame_buf[2], frame_buf[3], r.expo);
                r.y      = widen_coord(frame_buf[4], frame_buf[5], r.expo);
                r.z      = widen_coord(frame_buf[6], b, r.expo);
            end
            frames_due.push_back(r);
        end
    endtask

    always @(posedge aclk) begin : watch
        pos_report_t got;
        pos_report_t due;
        if (!aresetn) begin
            frames_due.delete();
            in_lock       = 1'b0;
            sync_run      = '0;
            slot          = '0;
            n_mismatch    = 0;
            n_pos_frames  = 0;
            n_lost_frames = 0;
        end else begin
            // reports leave before this edge's byte can queue a new one
            if (m_tvalid && m_tready) begin
                got.status = m_tuser[0];
                got.x      = m_tdata[tfsd_pkg::POS_W-1:0];
                got.y      = m_tdata[2*tfsd_pkg::POS_W-1:tfsd_pkg::POS_W];
                got.z      = m_tdata[3*tfsd_pkg::POS_W-1:2*tfsd_pkg::POS_W];
                got.expo   = m_tdata[3*tfsd_pkg::POS_W+tfsd_pkg::EXP_W-1:3*tfsd_pkg::POS_W];
                if (frames_due.size() == 0) begin
                    if (n_mismatch < 10)
                        $display("%t unexpected report st=%0d x=%0d y=%0d z=%0d e=%0d",
                                 $realtime, got.status, $signed(got.x), $signed(got.y),
                                 $signed(got.z), got.expo);
                    n_mismatch++;
                end else begin
                    due = frames_due.pop_front();
                    if (got.status != due.status || got.x != due.x ||
                        got.y != due.y || got.z != due.z || got.expo != due.expo) begin
                        if (n_mismatch < 10) begin
                            $display("%t report differs", $realtime);
                            $display("  expected st=%0d x=%0d y=%0d z=%0d e=%0d",
                                     due.status, $signed(due.x), $signed(due.y),
                                     $signed(due.z), due.expo);
                            $display("  actual   st=%0d x=%0d y=%0d z=%0d e=%0d",
                                     got.status, $signed(got.x), $signed(got.y),
                                     $signed(got.z), got.expo);
                        end
                        n_mismatch++;
                    end
                    if (due.status == tfsd_pkg::STATUS_LOST)
                        n_lost_frames++;
                    else
                        n_pos_frames++;
                end
            end
            if (s_tvalid && s_tready)
                decode_rx_byte(s_tdata);
        end
        n_pending = frames_due.size();
    end

endmodule

FILE: sim/tb_tracker_frame_sync_decoder.sv
// ---------------------------------------------------------------------------
// tb_tracker_frame_sync_decoder
// Stream test of the tracker frame sync decoder.
// ---------------------------------------------------------------------------
// A short opening sequence walks the hunter through clearing and keeping its
// count, locks, decodes one extreme frame and loses sync. Random sessions
// follow: maybe noise, a lock preamble, a run of random good frames and
// one broken frame. Both sides idle in random bursts and the receiver holds
// off once for a long stretch. The checker beside the block does the scoring.

module tb_tracker_frame_sync_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS      = 1500;
    localparam int CALM_TAIL    = 200;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SQUEEZE_AT   = 600;
    localparam int SQUEEZE_LEN  = 300;
    localparam int DRAIN_CYCLES = 16;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tfsd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                      m_tuser;

    int n_mismatch;
    int n_pending;
    int n_pos_frames;
    int n_lost_frames;

    int n_sent      = 0;
    bit send_gaps   = 1'b1;
    bit recv_gaps   = 1'b1;
    bit squeeze_done = 1'b0;

    tracker_frame_sync_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tfsd_decode_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .n_mismatch    (n_mismatch),
        .n_pending     (n_pending),
        .n_pos_frames  (n_pos_frames),
        .n_lost_frames (n_lost_frames)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ends the run once nothing has moved on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no request moved for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random hold-off bursts, plus one long squeeze mid-run
    initial begin : receiver
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!squeeze_done && n_sent >= SQUEEZE_AT) begin
                squeeze_done = 1'b1;
                m_tready <= 1'b0;
                repeat (SQUEEZE_LEN) @(posedge aclk);
            end else if (recv_gaps && n_sent < N_ITEMS - CALM_TAIL &&
                         $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (send_gaps && n_sent < N_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    function automatic logic [7:0] sync_byte();
        return tfsd_pkg::SYNC_NIBBLE | (8'($urandom) & ~tfsd_pkg::SYNC_MASK);
    endfunction

    function automatic logic [7:0] off_sync_byte();
        logic [3:0] nib;
        nib = 4'($urandom_range(0, 14));
        if (nib >= tfsd_pkg::SYNC_NIBBLE[7:4])
            nib = nib + 4'd1;
        return {nib, 4'($urandom)};
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // count to lock either on eight sync bytes or on two and six of anything
    task automatic lock_preamble();
        if ($urandom_range(0, 3) == 0) begin
            repeat (2) send_byte(sync_byte());
            repeat (6) send_byte(8'($urandom));
        end else begin
            repeat (8) send_byte(sync_byte());
        end
    endtask

    task automatic send_frame(input bit broken);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        b0 = sync_byte();
        b1 = sync_byte();
        if (broken) begin
            case ($urandom_range(0, 2))
                0:       b0 = off_sync_byte();
                1:       b1 = off_sync_byte();
                default: begin
                    b0 = off_sync_byte();
                    b1 = off_sync_byte();
                end
            endcase
        end
        cx = pick_coord();
        cy = pick_coord();
        cz = pick_coord();
        send_byte(b0);
        send_byte(b1);
        send_byte(cx[15:8]);
        send_byte(cx[7:0]);
        send_byte(cy[15:8]);
        send_byte(cy[7:0]);
        send_byte(cz[15:8]);
        send_byte(cz[7:0]);
    endtask

    initial begin : stimulus
        logic [7:0] opening [0:26];
        opening = '{
            // hunting: clear below two, keep counting from two, lock at eight
            8'h00, 8'h8f, 8'h00, 8'h80, 8'h81, 8'h12,
            8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h80,
            // exponent 3, most negative x, most positive y, z of minus one
            8'h83, 8'h8f, 8'h80, 8'h00, 8'h7f, 8'hff, 8'hff, 8'hff,
            // second header byte out of sync
            8'h80, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
        };
        do @(posedge aclk); while (!aresetn);

        foreach (opening[i])
            send_byte(opening[i]);

        while (n_sent < N_ITEMS) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                // mostly harmless noise, now and then anything at all
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 7) == 0)
                        send_byte(8'($urandom));
                    else
                        send_byte(off_sync_byte());
                end
            end
            lock_preamble();
            repeat ($urandom_range(0, 6)) send_frame(1'b0);
            send_frame(1'b1);
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d bytes through the hunter and frame gatherer", n_sent);
        $display("%0d position frames and %0d lost-sync reports checked, %0d mismatches",
                 n_pos_frames, n_lost_frames, n_mismatch);
        if (n_mismatch == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
